// ----- sv/atl_pkg.sv -----
// ----------------------------------------------------------------------------
// atl_pkg
// shared widths, codes and control types for the tilt low-pass block
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int SAMPLE_BITS = 14;
  localparam int RAW_W       = 16;
  localparam int RAW_SHIFT   = RAW_W - SAMPLE_BITS;
  localparam int G_W         = 13;
  localparam int FILT_W      = 11;
  localparam int OUT_W       = 16;
  localparam int SHIFT_DIV   = 3;
  // clamp and offset width: room for the larger operand plus one carry
  localparam int CMP_W       = ((SAMPLE_BITS > G_W) ? SAMPLE_BITS : G_W) + 1;
  localparam int IDX_W       = 1;

  localparam logic [OUT_W-1:0] ABSENT_CODE = 16'hEEEE;
  localparam logic [G_W-1:0]   ONE_G_RESET = 13'd4096;

  // register indexes on the write port
  localparam logic [IDX_W-1:0] REG_ONE_G   = 1'd0;
  localparam logic [IDX_W-1:0] REG_PRESENT = 1'd1;

  // pipeline control from the handshake unit to the datapath
  typedef struct packed {
    logic in_ready;
    logic load_s1;
    logic adv;
  } ctrl_t;

endpackage

// ----- sv/accel_tilt_lowpass_unit.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_lowpass_unit
// three-axis accelerometer tilt target and first-order low-pass per axis
// ----------------------------------------------------------------------------
//  channel   signals                                   direction  handshake
//  input     data_ready, x_raw, y_raw, z_raw           in         in_valid/in_ready
//  result    out_x, out_y, out_z                       out        out_valid/out_ready
//  config    wr_en, wr_index, wr_data                  in         write on wr_en
//
//  one word per cycle unless out_ready stalls; input register, then result register
//  the filter state update between input register and result register sets the rate
//  reset clears the filters to zero, one g to 4096 and marks the sensor absent
//  a held result stalls the input register, which then holds in_ready low
// ----------------------------------------------------------------------------
module accel_tilt_lowpass_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           data_ready,
  input  logic [atl_pkg::RAW_W-1:0]      x_raw,
  input  logic [atl_pkg::RAW_W-1:0]      y_raw,
  input  logic [atl_pkg::RAW_W-1:0]      z_raw,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [atl_pkg::OUT_W-1:0]      out_x,
  output logic [atl_pkg::OUT_W-1:0]      out_y,
  output logic [atl_pkg::OUT_W-1:0]      out_z,
  // register writes
  input  logic                           wr_en,
  input  logic [atl_pkg::IDX_W-1:0]      wr_index,
  input  logic [atl_pkg::G_W-1:0]        wr_data
);

  atl_pkg::ctrl_t ctrl;

  // configuration registers
  logic [atl_pkg::G_W-1:0] one_g;
  logic                    present;

  // input register
  logic                      dr_q;
  logic [atl_pkg::RAW_W-1:0] x_q;
  logic [atl_pkg::RAW_W-1:0] y_q;
  logic [atl_pkg::RAW_W-1:0] z_q;

  logic                       update;
  logic [atl_pkg::FILT_W-1:0] fx_new;
  logic [atl_pkg::FILT_W-1:0] fy_new;
  logic [atl_pkg::FILT_W-1:0] fz_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_g   <= atl_pkg::ONE_G_RESET;
      present <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        atl_pkg::REG_ONE_G:   one_g   <= wr_data;
        atl_pkg::REG_PRESENT: present <= wr_data[0];
      endcase
    end
  end

  atl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .out_valid (out_valid)
  );

  assign in_ready = ctrl.in_ready;

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      dr_q <= data_ready;
      x_q  <= x_raw;
      y_q  <= y_raw;
      z_q  <= z_raw;
    end
  end

  // filters move only on a ready frame while the sensor is present
  assign update = dr_q && present;

  atl_axis u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .adv      (ctrl.adv),
    .update   (update),
    .raw      (x_q),
    .one_g    (one_g),
    .filt_new (fx_new)
  );

  atl_axis u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .adv      (ctrl.adv),
    .update   (update),
    .raw      (y_q),
    .one_g    (one_g),
    .filt_new (fy_new)
  );

  atl_axis u_axis_z (
    .clk      (clk),
    .rst      (rst),
    .adv      (ctrl.adv),
    .update   (update),
    .raw      (z_q),
    .one_g    (one_g),
    .filt_new (fz_new)
  );

  // result register: filtered values, or the absent code on every axis
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_x <= present ? atl_pkg::OUT_W'(fx_new) : atl_pkg::ABSENT_CODE;
      out_y <= present ? atl_pkg::OUT_W'(fy_new) : atl_pkg::ABSENT_CODE;
      out_z <= present ? atl_pkg::OUT_W'(fz_new) : atl_pkg::ABSENT_CODE;
    end
  end

endmodule

// ----- sv/atl_axis.sv -----
// ----------------------------------------------------------------------------
// atl_axis
// one axis: tilt target from the raw word and the low-pass filter state
// ----------------------------------------------------------------------------
module atl_axis (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          update,
  input  logic [atl_pkg::RAW_W-1:0]     raw,
  input  logic [atl_pkg::G_W-1:0]       one_g,
  output logic [atl_pkg::FILT_W-1:0]    filt_new
);

  logic [atl_pkg::SAMPLE_BITS-1:0] sample;
  logic [atl_pkg::SAMPLE_BITS-1:0] mag;
  logic                            neg;
  logic [atl_pkg::CMP_W-1:0]       mag_x;
  logic [atl_pkg::CMP_W-1:0]       g_x;
  logic [atl_pkg::CMP_W-1:0]       clamp;
  logic [atl_pkg::CMP_W-1:0]       sum;
  logic [atl_pkg::FILT_W-1:0]      target;
  logic signed [atl_pkg::FILT_W:0] diff;
  logic signed [atl_pkg::FILT_W:0] step;
  logic [atl_pkg::FILT_W-1:0]      filt;
  logic [atl_pkg::FILT_W-1:0]      filt_next;

  // drop the low justification bits, keep the two's complement sample
  assign sample = raw[atl_pkg::RAW_W-1:atl_pkg::RAW_SHIFT];
  assign neg    = sample[atl_pkg::SAMPLE_BITS-1];
  assign mag    = neg ? (atl_pkg::SAMPLE_BITS'(0) - sample) : sample;

  assign mag_x  = atl_pkg::CMP_W'(mag);
  assign g_x    = atl_pkg::CMP_W'(one_g);
  assign clamp  = (mag_x > g_x) ? g_x : mag_x;
  assign sum    = neg ? (g_x + clamp) : (g_x - clamp);
  assign target = sum[atl_pkg::FILT_W+atl_pkg::SHIFT_DIV-1:atl_pkg::SHIFT_DIV];

  // floor shift of the signed difference
  assign diff      = $signed({1'b0, target}) - $signed({1'b0, filt});
  assign step      = diff >>> atl_pkg::SHIFT_DIV;
  assign filt_next = filt + step[atl_pkg::FILT_W-1:0];
  assign filt_new  = update ? filt_next : filt;

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0;
    end else if (adv) begin
      filt <= filt_new;
    end
  end

endmodule

// ----- sv/atl_ctrl.sv -----
// ----------------------------------------------------------------------------
// atl_ctrl
// valid/ready control for the input register and the result register
// ----------------------------------------------------------------------------
module atl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  output atl_pkg::ctrl_t ctrl,
  output logic           out_valid
);

  logic s1_valid;
  logic s1_valid_next;
  logic out_valid_next;
  logic room;

  // result register can take a new word this cycle
  assign room          = !out_valid || out_ready;
  assign ctrl.in_ready = !s1_valid || room;
  assign ctrl.load_s1  = in_valid && ctrl.in_ready;
  assign ctrl.adv      = s1_valid && room;

  assign s1_valid_next  = ctrl.load_s1 || (s1_valid && !room);
  assign out_valid_next = ctrl.adv || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/atl_check.sv -----
// ----------------------------------------------------------------------------
// atl_check
// port-level checks for the tilt low-pass block, bound to the top level
// ----------------------------------------------------------------------------
module atl_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [atl_pkg::OUT_W-1:0] out_x,
  input logic [atl_pkg::OUT_W-1:0] out_y,
  input logic [atl_pkg::OUT_W-1:0] out_z
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z))
    else $error("stalled result changed");

  // input is refused only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // all axes absent together, otherwise 11-bit filtered values
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((out_x == atl_pkg::ABSENT_CODE) && (out_y == atl_pkg::ABSENT_CODE)
        && (out_z == atl_pkg::ABSENT_CODE))
      || ((out_x[15:11] == 5'd0) && (out_y[15:11] == 5'd0) && (out_z[15:11] == 5'd0)))
    else $error("result out of range or mixed absent code");

endmodule

bind accel_tilt_lowpass_unit atl_check u_atl_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the accelerometer tilt low-pass unit: frames go in
// over valid/ready, every result word is checked against a cycle-free copy of
// the tilt fold and per-axis filter kept here, across several register
// settings, random gaps on both sides and one long result hold-off
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_FRAMES   = 50;
  localparam int SETTLE_CYCLES  = 6;   // idle margin after the last result word
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_FRAMES    = 40;
  localparam int IDLE_PERCENT   = 9;
  localparam logic [atl_pkg::G_W-1:0] G_MAX = '1;

  // result word as it leaves the block
  typedef struct packed {
    logic [atl_pkg::OUT_W-1:0] x;
    logic [atl_pkg::OUT_W-1:0] y;
    logic [atl_pkg::OUT_W-1:0] z;
  } tilt_word_t;

  // dut ports, all inputs known from time zero
  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       data_ready = 1'b0;
  logic [atl_pkg::RAW_W-1:0]  x_raw      = '0;
  logic [atl_pkg::RAW_W-1:0]  y_raw      = '0;
  logic [atl_pkg::RAW_W-1:0]  z_raw      = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [atl_pkg::OUT_W-1:0]  out_x;
  logic [atl_pkg::OUT_W-1:0]  out_y;
  logic [atl_pkg::OUT_W-1:0]  out_z;
  logic                       wr_en      = 1'b0;
  logic [atl_pkg::IDX_W-1:0]  wr_index   = '0;
  logic [atl_pkg::G_W-1:0]    wr_data    = '0;

  // shadow of the block: registers and filter state
  logic [atl_pkg::G_W-1:0]    cfg_one_g   = atl_pkg::ONE_G_RESET;
  logic                       cfg_present = 1'b0;
  logic [atl_pkg::FILT_W-1:0] filt_state [3] = '{default: '0};

  tilt_word_t        pending_words [$];

  // run bookkeeping
  int  errors       = 0;
  int  frames_sent  = 0;
  int  words_seen   = 0;
  int  absent_words = 0;
  bit  quiet        = 1'b0;  // no idling on either side while set
  int  hold_req     = 0;     // receiver hold-off, counted down by the receiver

  accel_tilt_lowpass_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_ready (data_ready),
    .x_raw      (x_raw),
    .y_raw      (y_raw),
    .z_raw      (z_raw),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // tilt fold and low-pass, per axis
  // ------------------------------------------------------------------

  // raw register pair -> 11-bit tilt target
  function automatic logic [atl_pkg::FILT_W-1:0] tilt_of(
      input logic [atl_pkg::RAW_W-1:0] raw, input logic [atl_pkg::G_W-1:0] g);
    int samp;
    int mag;
    int lim;
    lim  = int'(g);
    samp = int'(raw >> atl_pkg::RAW_SHIFT);
    if (samp & (1 << (atl_pkg::SAMPLE_BITS - 1))) begin
      // negative: magnitude, clamp to one g, then add one g
      mag = (-samp) & ((1 << atl_pkg::SAMPLE_BITS) - 1);
      if (mag > lim) mag = lim;
      mag = mag + lim;
    end else begin
      // positive: clamp, then distance below one g
      mag = samp;
      if (mag > lim) mag = lim;
      mag = lim - mag;
    end
    return atl_pkg::FILT_W'(mag >> atl_pkg::SHIFT_DIV);
  endfunction

  // one filter step with a floor shift of the difference
  function automatic logic [atl_pkg::FILT_W-1:0] lowpass_of(
      input logic [atl_pkg::FILT_W-1:0] cur, input logic [atl_pkg::FILT_W-1:0] tgt);
    int c;
    int t;
    c = int'(cur);
    t = int'(tgt);
    if (t >= c) return atl_pkg::FILT_W'(c + ((t - c) >> atl_pkg::SHIFT_DIV));
    return atl_pkg::FILT_W'(c - ((c - t + 7) >> atl_pkg::SHIFT_DIV));
  endfunction

  // update the shadow filters for one accepted frame and queue its word
  task automatic predict_frame(input logic dr, input logic [atl_pkg::RAW_W-1:0] xr,
                               input logic [atl_pkg::RAW_W-1:0] yr,
                               input logic [atl_pkg::RAW_W-1:0] zr);
    tilt_word_t w;
    if (!cfg_present) begin
      // sensor absent: filters frozen, fixed code on every axis
      w = '{x: atl_pkg::ABSENT_CODE, y: atl_pkg::ABSENT_CODE, z: atl_pkg::ABSENT_CODE};
    end else begin
      if (dr) begin
        filt_state[0] = lowpass_of(filt_state[0], tilt_of(xr, cfg_one_g));
        filt_state[1] = lowpass_of(filt_state[1], tilt_of(yr, cfg_one_g));
        filt_state[2] = lowpass_of(filt_state[2], tilt_of(zr, cfg_one_g));
      end
      w.x = atl_pkg::OUT_W'(filt_state[0]);
      w.y = atl_pkg::OUT_W'(filt_state[1]);
      w.z = atl_pkg::OUT_W'(filt_state[2]);
    end
    pending_words.push_back(w);
  endtask

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------

  function automatic bit take_gap();
    return !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // offer one frame; inputs move on the falling edge only
  task automatic send_frame(input logic dr, input logic [atl_pkg::RAW_W-1:0] xr,
                            input logic [atl_pkg::RAW_W-1:0] yr,
                            input logic [atl_pkg::RAW_W-1:0] zr);
    @(negedge clk);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_ready <= dr;
    x_raw      <= xr;
    y_raw      <= yr;
    z_raw      <= zr;
    // valid is high by now, so the word goes at the first edge with ready
    do @(posedge clk); while (!in_ready);
    predict_frame(dr, xr, yr, zr);
    frames_sent++;
  endtask

  // drop valid and wait until every queued word has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [atl_pkg::IDX_W-1:0] idx,
                           input logic [atl_pkg::G_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
    if (idx == atl_pkg::REG_ONE_G) cfg_one_g = val;
    else cfg_present = val[0];
  endtask

  // receiver: random stalls, or a counted hold-off when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        hold_req--;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // ------------------------------------------------------------------
  // result checker
  // ------------------------------------------------------------------

  task automatic check_axis(input string name, input logic [atl_pkg::OUT_W-1:0] exp_v,
                            input logic [atl_pkg::OUT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tilt_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word %h %h %h with nothing pending", out_x, out_y, out_z);
        errors++;
      end else begin
        w = pending_words.pop_front();
        check_axis("out_x", w.x, out_x);
        check_axis("out_y", w.y, out_y);
        check_axis("out_z", w.z, out_z);
        if (w.x == atl_pkg::ABSENT_CODE) absent_words++;
      end
      words_seen++;
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // raw word: full random, an edge value, or a sample near the clamp level
  function automatic logic [atl_pkg::RAW_W-1:0] pick_raw();
    int kind;
    int span;
    int s;
    kind = $urandom_range(0, 9);
    if (kind < 3) return atl_pkg::RAW_W'($urandom);
    if (kind == 3) begin
      case ($urandom_range(0, 5))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h7FFF;
        3: return 16'h8000;
        4: return 16'h7FFC;
        default: return 16'h8003;
      endcase
    end
    span = int'(cfg_one_g) + 16;
    s = int'($urandom_range(0, 2 * span)) - span;
    if (s > 8191) s = 8191;
    if (s < -8192) s = -8192;
    return {atl_pkg::SAMPLE_BITS'(s), atl_pkg::RAW_SHIFT'($urandom_range(0, 3))};
  endfunction

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // out of reset the sensor is absent: fixed code, filters must not move
  task automatic test_absent_after_reset();
    send_frame(1'b1, 16'h0000, 16'hFFFF, 16'h8000);
    send_frame(1'b1, 16'h7FFF, 16'h1234, 16'hABCD);
    send_frame(1'b0, 16'hFFFF, 16'h0000, 16'h5555);
    settle();
  endtask

  // sensor present with the reset one g level still in place
  task automatic test_reset_one_g();
    write_reg(atl_pkg::REG_PRESENT, atl_pkg::G_W'(1));
    send_frame(1'b1, 16'h0000, 16'h4000, 16'hC000);
    send_frame(1'b1, 16'h7FFC, 16'h8000, 16'hFFFF);
    send_frame(1'b0, 16'h1111, 16'h2222, 16'h3333);
    send_frame(1'b1, 16'h0003, 16'hFFFC, 16'h2000);
    settle();
  endtask

  // clamp extremes: largest and smallest one g, then zero one g, then absent with filters loaded
  task automatic test_clamp_extremes();
    write_reg(atl_pkg::REG_ONE_G, G_MAX);
    send_frame(1'b1, 16'h8000, 16'h7FFF, 16'h0000);
    send_frame(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_frame(1'b1, 16'h8004, 16'h7FF8, 16'h0004);
    send_frame(1'b0, 16'h0000, 16'h0000, 16'h0000);
    settle();
    write_reg(atl_pkg::REG_ONE_G, atl_pkg::G_W'(1));
    send_frame(1'b1, 16'hFFFF, 16'h0004, 16'h0000);
    send_frame(1'b1, 16'h8000, 16'h7FFF, 16'hFFF8);
    settle();
    // zero clamp level drives every axis toward zero
    write_reg(atl_pkg::REG_ONE_G, atl_pkg::G_W'(0));
    send_frame(1'b1, 16'h8000, 16'h7FFF, 16'h1234);
    send_frame(1'b1, 16'hFFFF, 16'h0000, 16'hC000);
    settle();
    // absent again with filters loaded: state has to survive
    write_reg(atl_pkg::REG_PRESENT, atl_pkg::G_W'(0));
    send_frame(1'b1, 16'h4000, 16'h4000, 16'h4000);
    settle();
    write_reg(atl_pkg::REG_PRESENT, atl_pkg::G_W'(1));
    send_frame(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle();
  endtask

  // random frames over several register settings
  task automatic test_random_phases();
    logic [atl_pkg::G_W-1:0] g;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       g = atl_pkg::G_W'(1);
        2:       g = G_MAX;
        3:       g = atl_pkg::ONE_G_RESET;
        default: g = atl_pkg::G_W'($urandom_range(1, 8191));
      endcase
      write_reg(atl_pkg::REG_ONE_G, g);
      // one phase with the sensor absent
      write_reg(atl_pkg::REG_PRESENT, atl_pkg::G_W'(ph != 5));
      // first phase runs without any idling on either side
      quiet = (ph == 0);
      for (int i = 0; i < PHASE_FRAMES; i++)
        send_frame($urandom_range(0, 99) < 85, pick_raw(), pick_raw(), pick_raw());
      settle();
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering: block fills, input stalls
  task automatic test_result_holdoff();
    write_reg(atl_pkg::REG_ONE_G, atl_pkg::G_W'($urandom_range(1, 8191)));
    write_reg(atl_pkg::REG_PRESENT, atl_pkg::G_W'(1));
    quiet    = 1'b1;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < HOLD_FRAMES; i++)
      send_frame(1'b1, pick_raw(), pick_raw(), pick_raw());
    quiet = 1'b0;
    settle();
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_absent_after_reset();
    test_reset_one_g();
    test_clamp_extremes();
    test_random_phases();
    test_result_holdoff();

    settle();
    $display("frames sent %0d, result words checked %0d (%0d with sensor absent)",
             frames_sent, words_seen, absent_words);
    $display("covered one g at 0, 1, 4096 and 8191, clamp edges, idle gaps and a long stall");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/atl_pkg.sv
sv/atl_axis.sv
sv/atl_ctrl.sv
sv/accel_tilt_lowpass_unit.sv
sv/atl_check.sv
bench/tb_top.sv
